[rtl/tmsu_pkg.sv]
// Package for the tally mean / standard error unit.
// Shared constants: widths, reset values, register indexes. No dependencies.
`default_nettype none

package tmsu_pkg;

  localparam int FracBitsDefault = 16;

  localparam int SumW    = 48;  // score_sum, score_square_sum, mean
  localparam int TagW    = 24;
  localparam int ErrW    = 47;  // unsigned error outputs
  localparam int RelW    = 32;
  localparam int CfgW    = 32;
  localparam int InDataW  = 120;
  localparam int OutDataW = 296;
  localparam int OutUsedW = 293;
  localparam int RelQuotW = 33; // relative error quotient bits before saturation

  localparam logic [CfgW-1:0] HistReset = 32'd1;
  localparam logic [CfgW-1:0] NormReset = 32'h0001_0000;

  localparam logic RegHistoryCount = 1'b0;
  localparam logic RegNormFactor   = 1'b1;

endpackage

`default_nettype wire

[rtl/tally_mean_stddev_unit.sv]
// Tally mean / standard error unit, top level.
// Depends on tmsu_pkg and tmsu_div_pipe.
//
// Usage:
//  - Input stream s_axis: tdata = {entry_tag, score_square_sum, score_sum}.
//    One request per cycle may be accepted (tvalid && tready).
//  - Output stream m_axis: one result per request, in order.
//  - Config port: cfg_we_i writes cfg_data_i into register cfg_index_i
//    (0 = history_count, 1 = normalization_factor). Write only while idle.
//  - Pipeline: S0-S3, the bit-per-stage divider for |Q*N - S*S| / N^3
//    (DW = max(96, 80+FracBits) bits), the bit-per-stage square root (SW =
//    (DW+1)/2 bits), P1, P2, the 33-stage relative error divider and the
//    output register.
//  - Throughput: one request per cycle while the pipeline is not stalled.
//  - Stall: the whole pipeline holds while the output register is full and
//    m_axis_tready_i is low; s_axis_tready_o drops in the same cycle.
//  - Reset: valid bits clear, history_count = 1, normalization = 1.0.
//  - N^3 is formed by a free-running multiply chain (nn_q, n3a_q/n3b_q, n3_q)
//    off the config registers, settled before any request reaches the divider.
`default_nettype none

module tally_mean_stddev_unit #(
  parameter int FracBits = tmsu_pkg::FracBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // score_sum[47:0], score_square_sum[95:48], entry_tag[119:96]
  input  wire logic [tmsu_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // entry_tag_out[23:0], mean_value[71:24], standard_error[118:72],
  // scaled_sigma[165:119], relative_error[197:166], normalized_mean[245:198],
  // normalized_error[292:246], pad[295:293]
  output logic [tmsu_pkg::OutDataW-1:0]      m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [tmsu_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int DW  = (80 + FracBits > 96) ? 80 + FracBits : 96;
  localparam int SW  = (DW + 1) / 2;
  localparam int RW  = SW + 3;
  localparam int SH  = (SW + 1) / 2;
  localparam int RDW = SW + FracBits;
  localparam int RQW = tmsu_pkg::RelQuotW;
  localparam int SBR = 264;

  // ---------------- configuration ----------------
  logic [31:0] hist_q, norm_q, n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= tmsu_pkg::HistReset;
      norm_q <= tmsu_pkg::NormReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tmsu_pkg::RegHistoryCount: hist_q <= cfg_data_i;
        tmsu_pkg::RegNormFactor:   norm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign n_eff = (hist_q == '0) ? 32'd1 : hist_q;

  // N^3, free running
  logic [63:0] nn_q;
  logic [63:0] n3a_q, n3b_q;
  logic [95:0] n3_q;
  always_ff @(posedge clk_i) begin
    nn_q  <= 64'(n_eff) * 64'(n_eff);
    n3a_q <= 64'(nn_q[63:32]) * 64'(n_eff);
    n3b_q <= 64'(nn_q[31:0]) * 64'(n_eff);
    n3_q  <= (96'(n3a_q) << 32) + 96'(n3b_q);
  end

  // ---------------- pipeline control ----------------
  logic out_valid_q;
  logic en;
  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // ---------------- S0: input capture ----------------
  logic        s0_vld_q, s1_vld_q, s2_vld_q, s3_vld_q;
  logic [47:0] s0_smag_q, s0_q_q;
  logic        s0_neg_q;
  logic [23:0] s0_tag_q;
  logic [47:0] in_s;

  assign in_s = s_axis_tdata_i[47:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_neg_q  <= in_s[47];
      s0_smag_q <= in_s[47] ? 48'(-in_s) : in_s;
      s0_q_q    <= s_axis_tdata_i[95:48];
      s0_tag_q  <= s_axis_tdata_i[119:96];
    end
  end

  // ---------------- S1: partial products ----------------
  logic [55:0] s1_ah_q, s1_al_q;
  logic [47:0] s1_hh_q, s1_hl_q, s1_lh_q, s1_ll_q;
  logic [47:0] s1_smag_q;
  logic        s1_neg_q;
  logic [23:0] s1_tag_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ah_q   <= 56'(s0_q_q[47:24]) * 56'(n_eff);
      s1_al_q   <= 56'(s0_q_q[23:0]) * 56'(n_eff);
      s1_hh_q   <= 48'(s0_smag_q[47:24]) * 48'(s0_smag_q[47:24]);
      s1_hl_q   <= 48'(s0_smag_q[47:24]) * 48'(s0_smag_q[23:0]);
      s1_lh_q   <= 48'(s0_smag_q[23:0]) * 48'(s0_smag_q[47:24]);
      s1_ll_q   <= 48'(s0_smag_q[23:0]) * 48'(s0_smag_q[23:0]);
      s1_smag_q <= s0_smag_q;
      s1_neg_q  <= s0_neg_q;
      s1_tag_q  <= s0_tag_q;
    end
  end

  // ---------------- S2: a = Q*N << F, b = S*S ----------------
  logic [DW-1:0] s2_a_q, s2_b_q;
  logic [79:0]   a80;
  logic [47:0]   s2_smag_q;
  logic          s2_neg_q;
  logic [23:0]   s2_tag_q;

  assign a80 = (80'(s1_ah_q) << 24) + 80'(s1_al_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_a_q    <= DW'({a80, {FracBits{1'b0}}});
      s2_b_q    <= DW'((96'(s1_hh_q) << 48) + ((96'(s1_hl_q) + 96'(s1_lh_q)) << 24)
                       + 96'(s1_ll_q));
      s2_smag_q <= s1_smag_q;
      s2_neg_q  <= s1_neg_q;
      s2_tag_q  <= s1_tag_q;
    end
  end

  // ---------------- S3: |a - b| ----------------
  logic [DW-1:0] s3_d_q;
  logic [47:0]   s3_smag_q;
  logic          s3_neg_q;
  logic [23:0]   s3_tag_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_d_q    <= (s2_a_q >= s2_b_q) ? s2_a_q - s2_b_q : s2_b_q - s2_a_q;
      s3_smag_q <= s2_smag_q;
      s3_neg_q  <= s2_neg_q;
      s3_tag_q  <= s2_tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= s_axis_tvalid_i;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // ---------------- dividers: d / N^3 and S / N, equal depth ----------------
  logic          var_vld, mean_vld;
  logic [DW-1:0] var_quot, mean_quot;
  logic [24:0]   var_side;

  tmsu_div_pipe #(.NW(DW), .DVW(DW), .QW(DW), .SBW(25)) u_var_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s3_vld_q), .dividend_i(s3_d_q), .divisor_i(DW'(n3_q)),
    .side_i({s3_neg_q, s3_tag_q}),
    .valid_o(var_vld), .quotient_o(var_quot), .side_o(var_side)
  );

  tmsu_div_pipe #(.NW(DW), .DVW(32), .QW(DW), .SBW(1)) u_mean_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s3_vld_q), .dividend_i(DW'(s3_smag_q)), .divisor_i(n_eff),
    .side_i(1'b0),
    .valid_o(mean_vld), .quotient_o(mean_quot), .side_o()
  );

  // ---------------- square root, one root bit per stage ----------------
  logic [RW-1:0]   sq_rem  [SW+1];
  logic [2*SW-1:0] sq_rad  [SW+1];
  logic [SW-1:0]   sq_root [SW+1];
  logic [72:0]     sq_side [SW+1];
  logic            sq_vld  [SW+1];

  assign sq_rem[0]  = '0;
  assign sq_rad[0]  = (2*SW)'(var_quot);
  assign sq_root[0] = '0;
  assign sq_side[0] = {var_side, mean_quot[47:0]};
  assign sq_vld[0]  = var_vld;

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [RW-1:0] shifted, trial, rem_d;
    logic          ge;

    always_comb begin
      shifted = {sq_rem[k][RW-3:0], sq_rad[k][2*SW-1 -: 2]};
      trial   = RW'({sq_root[k], 2'b01});
      ge      = shifted >= trial;
      rem_d   = ge ? shifted - trial : shifted;
    end

    logic [RW-1:0]   rem_q;
    logic [2*SW-1:0] rad_q;
    logic [SW-1:0]   root_q;
    logic [72:0]     side_q;
    logic            vld_q;

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q  <= rem_d;
        rad_q  <= sq_rad[k] << 2;
        root_q <= {sq_root[k][SW-2:0], ge};
        side_q <= sq_side[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= sq_vld[k];
      end
    end

    assign sq_rem[k+1]  = rem_q;
    assign sq_rad[k+1]  = rad_q;
    assign sq_root[k+1] = root_q;
    assign sq_side[k+1] = side_q;
    assign sq_vld[k+1]  = vld_q;
  end

  // ---------------- P1: products of se and mean ----------------
  logic [SW-1:0]      se;
  logic [47:0]        sq_mmag;
  logic               p1_vld_q, p2_vld_q;
  logic [SH+31:0]     p1_sn_lo_q, p1_sm_lo_q;
  logic [SW-SH+31:0]  p1_sn_hi_q, p1_sm_hi_q;
  logic [55:0]        p1_mm_lo_q, p1_mm_hi_q;
  logic [SW-1:0]      p1_se_q;
  logic [47:0]        p1_mmag_q;
  logic               p1_neg_q;
  logic [23:0]        p1_tag_q;

  assign se      = sq_root[SW];
  assign sq_mmag = sq_side[SW][47:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_sn_lo_q <= (SH+32)'(se[SH-1:0]) * (SH+32)'(n_eff);
      p1_sn_hi_q <= (SW-SH+32)'(se[SW-1:SH]) * (SW-SH+32)'(n_eff);
      p1_sm_lo_q <= (SH+32)'(se[SH-1:0]) * (SH+32)'(norm_q);
      p1_sm_hi_q <= (SW-SH+32)'(se[SW-1:SH]) * (SW-SH+32)'(norm_q);
      p1_mm_lo_q <= 56'(sq_mmag[23:0]) * 56'(norm_q);
      p1_mm_hi_q <= 56'(sq_mmag[47:24]) * 56'(norm_q);
      p1_se_q    <= se;
      p1_mmag_q  <= sq_mmag;
      p1_neg_q   <= sq_side[SW][72];
      p1_tag_q   <= sq_side[SW][71:48];
    end
  end

  // ---------------- P2: sums and saturation ----------------
  logic [SW+31:0] sen, senorm, senorm_f;
  logic [79:0]    mn, mn_f;
  logic [47:0]    nm_lim, nmmag;
  logic [RDW-1:0] rel_dvd;

  logic [23:0]    p2_tag_q;
  logic [47:0]    p2_mean_q, p2_nmean_q, p2_mmag_q;
  logic [46:0]    p2_se_q, p2_scaled_q, p2_nerr_q;
  logic           p2_neg_q, p2_sat_q, p2_mzero_q;
  logic [RDW-1:0] p2_dvd_q;

  always_comb begin
    sen      = ((SW+32)'(p1_sn_hi_q) << SH) + (SW+32)'(p1_sn_lo_q);
    senorm   = ((SW+32)'(p1_sm_hi_q) << SH) + (SW+32)'(p1_sm_lo_q);
    senorm_f = senorm >> FracBits;
    mn       = (80'(p1_mm_hi_q) << 24) + 80'(p1_mm_lo_q);
    mn_f     = mn >> FracBits;
    nm_lim   = p1_neg_q ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    nmmag    = (mn_f > 80'(nm_lim)) ? nm_lim : mn_f[47:0];
    rel_dvd  = {p1_se_q, {FracBits{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_tag_q    <= p1_tag_q;
      p2_mean_q   <= p1_neg_q ? 48'(-p1_mmag_q) : p1_mmag_q;
      p2_se_q     <= (|p1_se_q[SW-1:47]) ? '1 : p1_se_q[46:0];
      p2_scaled_q <= (|sen[SW+31:47]) ? '1 : sen[46:0];
      p2_nerr_q   <= (|senorm_f[SW+31:47]) ? '1 : senorm_f[46:0];
      p2_nmean_q  <= (p1_neg_q && nmmag != '0) ? 48'(-nmmag) : nmmag;
      p2_neg_q    <= p1_neg_q;
      // quotient would need more than RelQuotW bits
      p2_sat_q    <= (rel_dvd >> RQW) >= RDW'(p1_mmag_q);
      p2_mzero_q  <= (p1_mmag_q == '0);
      p2_mmag_q   <= (p1_mmag_q == '0) ? 48'd1 : p1_mmag_q;
      p2_dvd_q    <= rel_dvd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= sq_vld[SW];
      p2_vld_q <= p1_vld_q;
    end
  end

  // ---------------- relative error divider ----------------
  logic           rel_vld;
  logic [RQW-1:0] rel_quot;
  logic [SBR-1:0] rel_side;

  tmsu_div_pipe #(.NW(RDW), .DVW(48), .QW(RQW), .SBW(SBR)) u_rel_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(p2_vld_q), .dividend_i(p2_dvd_q), .divisor_i(p2_mmag_q),
    .side_i({p2_mzero_q, p2_sat_q, p2_neg_q, p2_nerr_q, p2_nmean_q,
             p2_scaled_q, p2_se_q, p2_mean_q, p2_tag_q}),
    .valid_o(rel_vld), .quotient_o(rel_quot), .side_o(rel_side)
  );

  // ---------------- output register ----------------
  logic           r_mzero, r_sat, r_neg;
  logic [RQW-1:0] r_lim, relmag;
  logic [31:0]    rel_err;

  assign r_mzero = rel_side[263];
  assign r_sat   = rel_side[262];
  assign r_neg   = rel_side[261];

  always_comb begin
    r_lim = r_neg ? RQW'(33'h0_8000_0000) : RQW'(33'h0_7FFF_FFFF);
    if (r_mzero) begin
      relmag = '0;
    end else if (r_sat || rel_quot > r_lim) begin
      relmag = r_lim;
    end else begin
      relmag = rel_quot;
    end
    rel_err = (r_neg && relmag != '0) ? 32'(-relmag) : relmag[31:0];
  end

  logic [tmsu_pkg::OutDataW-1:0] out_data_q;

  // side: tag[23:0] mean[71:24] se[118:72] scaled[165:119] nmean[213:166] nerr[260:214]
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {3'b000, rel_side[260:214], rel_side[213:166], rel_err,
                     rel_side[165:119], rel_side[118:72], rel_side[71:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= rel_vld;
    end
  end

  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tvalid_o = out_valid_q;

  // ---------------- assertions ----------------
  a_div_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_vld == var_vld)
    else $error("mean and variance dividers out of step");

  a_rel_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[197:166] != '0) |-> out_data_q[197] == out_data_q[71])
    else $error("relative error sign differs from mean sign");

  a_zero_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[118:72] == '0)
      |-> (out_data_q[165:119] == '0 && out_data_q[292:246] == '0))
    else $error("scaled error nonzero with zero standard error");

endmodule

`default_nettype wire

[rtl/tmsu_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Used by tally_mean_stddev_unit; depends on nothing else.
`default_nettype none

module tmsu_div_pipe #(
  parameter int NW  = 48,  // dividend width
  parameter int DVW = 32,  // divisor width
  parameter int QW  = 48,  // quotient bits = stages
  parameter int SBW = 8    // sideband width
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [NW-1:0]  dividend_i,
  input  wire logic [DVW-1:0] divisor_i,
  input  wire logic [SBW-1:0] side_i,
  output logic                valid_o,
  output logic [QW-1:0]       quotient_o,
  output logic [SBW-1:0]      side_o
);

  logic [DVW-1:0] rem  [QW+1];
  logic [QW-1:0]  work [QW+1];
  logic [DVW-1:0] dvs  [QW+1];
  logic [SBW-1:0] side [QW+1];
  logic           vld  [QW+1];

  // upper dividend bits seed the remainder; caller keeps them below the divisor
  assign rem[0]  = DVW'(dividend_i >> QW);
  assign work[0] = QW'(dividend_i);
  assign dvs[0]  = divisor_i;
  assign side[0] = side_i;
  assign vld[0]  = valid_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DVW:0]   shifted;
    logic           ge;
    logic [DVW-1:0] rem_d;
    logic [QW-1:0]  work_d;

    always_comb begin
      shifted = {rem[k], work[k][QW-1]};
      ge      = shifted >= {1'b0, dvs[k]};
      rem_d   = ge ? DVW'(shifted - {1'b0, dvs[k]}) : DVW'(shifted);
      work_d  = {work[k][QW-2:0], ge};
    end

    logic [DVW-1:0] rem_q;
    logic [QW-1:0]  work_q;
    logic [DVW-1:0] dvs_q;
    logic [SBW-1:0] side_q;
    logic           vld_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        work_q <= work_d;
        dvs_q  <= dvs[k];
        side_q <= side[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[k];
      end
    end

    assign rem[k+1]  = rem_q;
    assign work[k+1] = work_q;
    assign dvs[k+1]  = dvs_q;
    assign side[k+1] = side_q;
    assign vld[k+1]  = vld_q;
  end

  assign valid_o    = vld[QW];
  assign quotient_o = work[QW];
  assign side_o     = side[QW];

endmodule

`default_nettype wire
